/* rtl/hrb_pkg.sv */
`timescale 1ns / 1ps
// Package for the history ring buffer: widths, register and mode codes,
// sequencer states and the chain control struct. No dependencies.
package hrb_pkg;

  localparam int unsigned MaxDepth = 16;
  localparam int unsigned IdW      = 32;
  localparam int unsigned CntW     = 5;
  localparam int unsigned AddrW    = 3;

  localparam logic [IdW-1:0] EmptyMark = '1;

  localparam logic [1:0] ModeStream = 2'd0;
  localparam logic [1:0] ModeKeep   = 2'd1;
  localparam logic [1:0] ModeLatch  = 2'd2;

  localparam logic RegMode  = 1'b0;
  localparam logic RegDepth = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StFlush
  } hrb_state_e;

  typedef struct packed {
    logic clr;
    logic shift;
  } chain_ctl_t;

endpackage

/* rtl/hrb_cell.sv */
`timescale 1ns / 1ps
// One storage cell of the history chain: holds one id, takes its
// neighbour's id on a shift. Depends on hrb_pkg.
module hrb_cell import hrb_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  chain_ctl_t     ctl_i,
  input  logic [IdW-1:0] din_i,
  output logic [IdW-1:0] q_o
);

  logic [IdW-1:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (ctl_i.clr) begin
      val_d = EmptyMark;
    end else if (ctl_i.shift) begin
      val_d = din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= EmptyMark;
    end else begin
      val_q <= val_d;
    end
  end

  assign q_o = val_q;

endmodule

/* rtl/hrb_chain.sv */
`timescale 1ns / 1ps
// Row of hrb_cell instances, newest id at cell 0, and the tail tap at the
// current effective depth. Depends on hrb_pkg and hrb_cell.
module hrb_chain import hrb_pkg::*; #(
  parameter int unsigned MAX_DEPTH = MaxDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  chain_ctl_t      ctl_i,
  input  logic [IdW-1:0]  din_i,
  input  logic [CntW-1:0] depth_i,
  output logic [IdW-1:0]  tail_o
);

  localparam int unsigned IdxW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [IdW-1:0]  cell_q [MAX_DEPTH];
  logic [CntW-1:0] tail_full;
  logic [IdxW-1:0] tail_idx;

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    logic [IdW-1:0] cell_din;
    if (i == 0) begin : g_head
      assign cell_din = din_i;
    end else begin : g_body
      assign cell_din = cell_q[i-1];
    end
    hrb_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_i),
      .din_i  (cell_din),
      .q_o    (cell_q[i])
    );
  end

  assign tail_full = depth_i - CntW'(1);
  assign tail_idx  = IdxW'(tail_full);
  assign tail_o    = cell_q[tail_idx];

endmodule

/* rtl/hrb_cfg.sv */
`timescale 1ns / 1ps
// APB register file for mode and history depth, and the effective depth.
// Depends on hrb_pkg.
module hrb_cfg import hrb_pkg::*; #(
  parameter int unsigned MAX_DEPTH = MaxDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [1:0]       mode_o,
  output logic [CntW-1:0]  depth_o,
  output logic             wr_o
);

  logic [1:0]      mode_q, mode_d;
  logic [CntW-1:0] hdep_q, hdep_d;
  logic            wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_comb begin
    mode_d = mode_q;
    hdep_d = hdep_q;
    if (wr) begin
      case (paddr[2])
        RegMode:  mode_d = pwdata[1:0];
        RegDepth: hdep_d = pwdata[CntW-1:0];
        default:  mode_d = mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeKeep;
      hdep_q <= CntW'(1);
    end else begin
      mode_q <= mode_d;
      hdep_q <= hdep_d;
    end
  end

  always_comb begin
    case (paddr[2])
      RegMode:  prdata = {30'd0, mode_q};
      RegDepth: prdata = {{(32 - CntW){1'b0}}, hdep_q};
      default:  prdata = '0;
    endcase
  end

  always_comb begin
    if (mode_q == ModeLatch || hdep_q == '0) begin
      depth_o = CntW'(1);
    end else if (32'(hdep_q) > 32'(MAX_DEPTH)) begin
      depth_o = CntW'(MAX_DEPTH);
    end else begin
      depth_o = hdep_q;
    end
  end

  assign mode_o = mode_q;
  assign wr_o   = wr;

endmodule

/* rtl/history_ring_buffer.sv */
`timescale 1ns / 1ps
// History ring buffer of 32-bit ids, top level. Depends on hrb_pkg,
// hrb_cfg, hrb_chain and hrb_cell.
//
// Input stream: tuser selects push (0) or history read (1), tdata carries the id.
// Output stream: tdata = value and fill count, tuser = value valid, tlast
// marks the final result of a transaction. Ids live in a chain of cells,
// newest first; in keep and latch modes a push shifts the chain and returns
// the id falling off the tail at the effective depth D.
// A push is answered in the cycle after acceptance from the output register
// and a new push is taken every cycle while the output is drained. A history
// read rotates the chain once through all D cells, one cell a cycle, then
// flushes the last pending entry; no input is taken until the flush is done.
// One entry is held back to find the final result, so results appear
// from the second non-empty cell on.
// A stalled receiver holds the output register; the rotation then waits on
// each non-empty cell after the first. Reset gives keep-last mode, depth one,
// and an empty store; any register write empties the store.
module history_ring_buffer import hrb_pkg::*; #(
  parameter int unsigned MAX_DEPTH = MaxDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // APB configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input transactions
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [31:0]      s_axis_tdata,  // [31:0] block_value
  input  logic             s_axis_tuser,  // [0] kind
  // results
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // [31:0] value, [36:32] fill_count, rest 0
  output logic             m_axis_tuser,  // [0] value_valid
  output logic             m_axis_tlast
);

  logic [1:0]      mode;
  logic [CntW-1:0] depth;
  logic            cfg_wr;
  logic            stores;

  hrb_state_e      state_q, state_d;
  chain_ctl_t      ctl;
  logic [IdW-1:0]  shift_din, tail;

  logic [CntW-1:0] held_q, held_d;
  logic [CntW-1:0] step_q, step_d;
  logic [IdW-1:0]  pend_q, pend_d;
  logic            pend_v_q, pend_v_d;

  logic            ov_q, ov_d;
  logic [IdW-1:0]  oval_q, oval_d;
  logic            ovv_q, ovv_d;
  logic            olast_q, olast_d;
  logic [CntW-1:0] ofill_q, ofill_d;

  logic            out_free, in_fire, adv, load;
  logic [IdW-1:0]  ld_val;
  logic            ld_vv, ld_last;

  hrb_cfg #(.MAX_DEPTH(MAX_DEPTH)) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode_o  (mode),
    .depth_o (depth),
    .wr_o    (cfg_wr)
  );

  hrb_chain #(.MAX_DEPTH(MAX_DEPTH)) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .din_i   (shift_din),
    .depth_i (depth),
    .tail_o  (tail)
  );

  assign stores   = (mode == ModeKeep) || (mode == ModeLatch);
  assign out_free = !ov_q || m_axis_tready;
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ctl.clr       = cfg_wr;
    ctl.shift     = 1'b0;
    shift_din     = tail;
    adv           = 1'b0;
    load          = 1'b0;
    ld_val        = EmptyMark;
    ld_vv         = 1'b0;
    ld_last       = 1'b1;
    pend_d        = pend_q;
    pend_v_d      = pend_v_q;
    case (state_q)
      StIdle: begin
        s_axis_tready = out_free;
        if (in_fire && !s_axis_tuser) begin
          load = 1'b1;
          if (stores) begin
            ctl.shift = 1'b1;
            shift_din = s_axis_tdata;
            ld_val    = tail;
            ld_vv     = (tail != EmptyMark);
          end
        end
      end
      StWalk: begin
        if (tail == EmptyMark) begin
          adv = 1'b1;
        end else if (!pend_v_q) begin
          adv      = 1'b1;
          pend_d   = tail;
          pend_v_d = 1'b1;
        end else if (out_free) begin
          adv     = 1'b1;
          pend_d  = tail;
          load    = 1'b1;
          ld_val  = pend_q;
          ld_vv   = 1'b1;
          ld_last = 1'b0;
        end
        ctl.shift = adv;
      end
      StFlush: begin
        if (out_free) begin
          load     = 1'b1;
          ld_val   = pend_v_q ? pend_q : EmptyMark;
          ld_vv    = pend_v_q;
          pend_v_d = 1'b0;
        end
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_fire && s_axis_tuser) state_d = StWalk;
      StWalk:  if (adv && step_q == CntW'(1)) state_d = StFlush;
      StFlush: if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    step_d = step_q;
    held_d = held_q;
    if (cfg_wr) begin
      held_d = '0;
    end else if (in_fire && !s_axis_tuser && stores && held_q < depth) begin
      held_d = held_q + CntW'(1);
    end
    if (in_fire && s_axis_tuser) begin
      step_d = depth;
    end else if (adv) begin
      step_d = step_q - CntW'(1);
    end
  end

  always_comb begin
    ov_d    = ov_q;
    oval_d  = oval_q;
    ovv_d   = ovv_q;
    olast_d = olast_q;
    ofill_d = ofill_q;
    if (load) begin
      ov_d    = 1'b1;
      oval_d  = ld_val;
      ovv_d   = ld_vv;
      olast_d = ld_last;
      ofill_d = held_d;
    end else if (m_axis_tready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      held_q   <= '0;
      step_q   <= '0;
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      held_q   <= held_d;
      step_q   <= step_d;
      pend_v_q <= pend_v_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q  <= pend_d;
    oval_q  <= oval_d;
    ovv_q   <= ovv_d;
    olast_q <= olast_d;
    ofill_q <= ofill_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {3'd0, ofill_q, oval_q};
  assign m_axis_tuser  = ovv_q;
  assign m_axis_tlast  = olast_q;

endmodule
